@@ sv/ffo_pkg.sv @@
// ffo_pkg: shared types and constants for the frame descriptor queue.
// Used by ffo_cell and frame_fifo_with_overflow_policy; no dependencies.
`default_nettype none
package ffo_pkg;

  localparam int unsigned DefDepth      = 64;
  localparam int unsigned DefLenBits    = 16;
  localparam int unsigned DefHandleBits = 16;

  localparam int unsigned TotalW  = 22;
  localparam int unsigned LimitW  = 7;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 7;
  localparam int unsigned OpW     = 2;

  localparam logic [OpW-1:0] OpEnq   = 2'd0;
  localparam logic [OpW-1:0] OpDeq   = 2'd1;
  localparam logic [OpW-1:0] OpClear = 2'd2;

  localparam logic [CfgIdxW-1:0] RegMaxFrames = 1'd0;
  localparam logic [CfgIdxW-1:0] RegDropNew   = 1'd1;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage
`default_nettype wire

@@ sv/frame_fifo_with_overflow_policy.sv @@
// frame_fifo_with_overflow_policy: frame descriptor queue with drop policy.
// Depends on ffo_pkg and ffo_cell.
//
// Usage:
//   Pulse start with op_i (enqueue, dequeue, clear) and the frame word.
//   busy stays low: a command is taken in every cycle.
//   The result word appears in the cycle after the command, for one cycle,
//   marked by done_o; it carries dequeue data, drop report, occupancy and
//   byte total after that command.
//   Throughput 1 command per cycle, set by the single update of the cell
//   chain and the counters at each edge.
//   Entries live in a chain of cells ordered oldest first; a dequeue or an
//   oldest-frame drop shifts every cell one place toward the head, a push
//   loads the cell at the fill level, or the last used one after a drop.
//   Configuration: cfg_we_i writes register cfg_idx_i (0 max_frames,
//   1 drop_new) at that edge; write only while idle.
//   Reset empties the queue, zeroes the byte total, sets max_frames to 64
//   and drop_new to 0. The receiver cannot stall results.
`default_nettype none
module frame_fifo_with_overflow_policy #(
  parameter int unsigned DEPTH       = ffo_pkg::DefDepth,
  parameter int unsigned LEN_BITS    = ffo_pkg::DefLenBits,
  parameter int unsigned HANDLE_BITS = ffo_pkg::DefHandleBits,
  localparam int unsigned CntW       = $clog2(DEPTH + 1)
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 start,
  output logic                                busy,
  input  wire logic [ffo_pkg::OpW-1:0]        op_i,
  input  wire logic [HANDLE_BITS-1:0]         frame_handle_i,
  input  wire logic [LEN_BITS-1:0]            frame_bytes_i,
  input  wire                                 cfg_we_i,
  input  wire logic [ffo_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [ffo_pkg::CfgW-1:0]       cfg_data_i,
  output logic                                done_o,
  output logic                                deq_valid_o,
  output logic [HANDLE_BITS-1:0]              deq_handle_o,
  output logic [LEN_BITS-1:0]                 deq_bytes_o,
  output logic                                dropped_o,
  output logic [HANDLE_BITS-1:0]              dropped_handle_o,
  output logic [CntW-1:0]                     occupancy_o,
  output logic [ffo_pkg::TotalW-1:0]          byte_total_o
);
  import ffo_pkg::*;

  localparam int unsigned IdxW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CmpW  = (CntW > LimitW) ? CntW : LimitW;
  localparam int unsigned SumW  = (LEN_BITS > TotalW) ? LEN_BITS : TotalW;
  localparam logic [CmpW-1:0] DepthC = CmpW'(DEPTH);

  // configuration
  logic [LimitW-1:0] max_frames_q;
  logic              drop_new_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frames_q <= LimitW'(64);
      drop_new_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMaxFrames: max_frames_q <= cfg_data_i[LimitW-1:0];
        RegDropNew:   drop_new_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // cell chain
  logic [HANDLE_BITS-1:0] cell_handle [DEPTH];
  logic [LEN_BITS-1:0]    cell_len    [DEPTH];
  cell_ctrl_t             cell_ctrl   [DEPTH];

  logic            do_shift, do_load;
  logic [IdxW-1:0] load_idx;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [HANDLE_BITS-1:0] nxt_handle;
    logic [LEN_BITS-1:0]    nxt_len;
    if (i == DEPTH - 1) begin : g_last
      assign nxt_handle = cell_handle[i];
      assign nxt_len    = cell_len[i];
    end else begin : g_mid
      assign nxt_handle = cell_handle[i+1];
      assign nxt_len    = cell_len[i+1];
    end
    assign cell_ctrl[i].shift = do_shift;
    assign cell_ctrl[i].load  = do_load && (load_idx == IdxW'(i));

    ffo_cell #(
      .HandleBits (HANDLE_BITS),
      .LenBits    (LEN_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl[i]),
      .new_handle_i (frame_handle_i),
      .new_len_i    (frame_bytes_i),
      .nxt_handle_i (nxt_handle),
      .nxt_len_i    (nxt_len),
      .handle_o     (cell_handle[i]),
      .len_o        (cell_len[i])
    );
  end

  // control state
  logic [CntW-1:0]   count_q, count_d;
  logic [TotalW-1:0] total_q, total_d;

  logic [CmpW-1:0] limit, count_ext;
  logic            full;
  logic            go;

  assign go        = start && !busy;
  assign busy      = 1'b0;
  assign count_ext = CmpW'(count_q);
  assign limit     = (CmpW'(max_frames_q) > DepthC) ? DepthC : CmpW'(max_frames_q);
  assign full      = (count_ext >= limit);

  logic [SumW-1:0] sum_w;

  logic                   res_dv, res_dr;
  logic [HANDLE_BITS-1:0] res_dh, res_drh;
  logic [LEN_BITS-1:0]    res_dl;

  always_comb begin
    do_shift = 1'b0;
    do_load  = 1'b0;
    load_idx = count_q[IdxW-1:0];
    count_d  = count_q;
    sum_w    = SumW'(total_q);
    res_dv   = 1'b0;
    res_dh   = '0;
    res_dl   = '0;
    res_dr   = 1'b0;
    res_drh  = '0;
    if (go) begin
      case (op_i)
        OpEnq: begin
          if (limit == '0) begin
            res_dr  = 1'b1;
            res_drh = frame_handle_i;
          end else if (full) begin
            res_dr = 1'b1;
            if (drop_new_q) begin
              res_drh = frame_handle_i;
            end else begin
              res_drh  = cell_handle[0];
              do_shift = 1'b1;
              do_load  = 1'b1;
              load_idx = IdxW'(count_q - CntW'(1));
              sum_w    = SumW'(total_q) - SumW'(cell_len[0]) + SumW'(frame_bytes_i);
            end
          end else begin
            do_load = 1'b1;
            count_d = count_q + CntW'(1);
            sum_w   = SumW'(total_q) + SumW'(frame_bytes_i);
          end
        end
        OpDeq: begin
          if (count_q != '0) begin
            do_shift = 1'b1;
            count_d  = count_q - CntW'(1);
            sum_w    = SumW'(total_q) - SumW'(cell_len[0]);
            res_dv   = 1'b1;
            res_dh   = cell_handle[0];
            res_dl   = cell_len[0];
          end
        end
        OpClear: begin
          count_d = '0;
          sum_w   = '0;
        end
        default: ;
      endcase
    end
    total_d = sum_w[TotalW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
      done_o  <= 1'b0;
    end else begin
      count_q <= count_d;
      total_q <= total_d;
      done_o  <= go;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (go) begin
      deq_valid_o      <= res_dv;
      deq_handle_o     <= res_dh;
      deq_bytes_o      <= res_dl;
      dropped_o        <= res_dr;
      dropped_handle_o <= res_drh;
      occupancy_o      <= count_d;
      byte_total_o     <= total_d;
    end
  end

endmodule
`default_nettype wire

@@ sv/ffo_cell.sv @@
// ffo_cell: one slot of the shifting descriptor chain.
// Depends on ffo_pkg for the cell control struct.
`default_nettype none
module ffo_cell #(
  parameter int unsigned HandleBits = 16,
  parameter int unsigned LenBits    = 16
) (
  input  wire                        clk_i,
  input  ffo_pkg::cell_ctrl_t        ctrl_i,
  input  wire logic [HandleBits-1:0] new_handle_i,
  input  wire logic [LenBits-1:0]    new_len_i,
  input  wire logic [HandleBits-1:0] nxt_handle_i,
  input  wire logic [LenBits-1:0]    nxt_len_i,
  output logic [HandleBits-1:0]      handle_o,
  output logic [LenBits-1:0]         len_o
);
  import ffo_pkg::*;

  logic [HandleBits-1:0] handle_q, handle_d;
  logic [LenBits-1:0]    len_q, len_d;

  always_comb begin
    handle_d = handle_q;
    len_d    = len_q;
    if (ctrl_i.load) begin
      handle_d = new_handle_i;
      len_d    = new_len_i;
    end else if (ctrl_i.shift) begin
      handle_d = nxt_handle_i;
      len_d    = nxt_len_i;
    end
  end

  always_ff @(posedge clk_i) begin
    handle_q <= handle_d;
    len_q    <= len_d;
  end

  assign handle_o = handle_q;
  assign len_o    = len_q;

endmodule
`default_nettype wire

@@ tb/sv/tb_frame_fifo_with_overflow_policy.sv @@
`timescale 1ns / 1ps
// tb_frame_fifo_with_overflow_policy: self-checking bench for the frame descriptor queue.
// Predicts every result word from a queue model and checks it; needs ffo_pkg and the RTL.
module tb_frame_fifo_with_overflow_policy;
  import ffo_pkg::*;

  localparam logic [OpW-1:0] OpIdle = 2'd3;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles = 4;

  typedef struct packed {
    logic [15:0] handle;
    logic [15:0] len;
  } frame_t;

  typedef struct packed {
    logic        deq_valid;
    logic [15:0] deq_handle;
    logic [15:0] deq_bytes;
    logic        dropped;
    logic [15:0] dropped_handle;
    logic [6:0]  occupancy;
    logic [21:0] byte_total;
  } qres_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [OpW-1:0] op_i = OpIdle;
  logic [15:0] frame_handle_i = '0;
  logic [15:0] frame_bytes_i = '0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic done_o;
  logic deq_valid_o;
  logic [15:0] deq_handle_o;
  logic [15:0] deq_bytes_o;
  logic dropped_o;
  logic [15:0] dropped_handle_o;
  logic [6:0] occupancy_o;
  logic [TotalW-1:0] byte_total_o;

  frame_t held_frames[$];
  logic [21:0] held_bytes = '0;
  logic [6:0] limit_reg = 7'd64;
  logic drop_new_reg = 1'b0;
  qres_t pending_results[$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit no_gaps = 1'b0;

  frame_fifo_with_overflow_policy u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .op_i            (op_i),
    .frame_handle_i  (frame_handle_i),
    .frame_bytes_i   (frame_bytes_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .done_o          (done_o),
    .deq_valid_o     (deq_valid_o),
    .deq_handle_o    (deq_handle_o),
    .deq_bytes_o     (deq_bytes_o),
    .dropped_o       (dropped_o),
    .dropped_handle_o(dropped_handle_o),
    .occupancy_o     (occupancy_o),
    .byte_total_o    (byte_total_o)
  );

  always #4 clk_i = ~clk_i;

  task automatic predict_queue(input logic [OpW-1:0] op, input logic [15:0] h,
                               input logic [15:0] b, output qres_t r);
    frame_t f;
    int unsigned lim;
    r = '0;
    lim = (limit_reg > 7'd64) ? 64 : limit_reg;
    case (op)
      OpEnq: begin
        if (lim == 0) begin
          r.dropped = 1'b1;
          r.dropped_handle = h;
        end else if (held_frames.size() >= lim) begin
          r.dropped = 1'b1;
          if (drop_new_reg) begin
            r.dropped_handle = h;
          end else begin
            f = held_frames.pop_front();
            held_bytes = held_bytes - f.len;
            r.dropped_handle = f.handle;
            held_frames.push_back({h, b});
            held_bytes = held_bytes + b;
          end
        end else begin
          held_frames.push_back({h, b});
          held_bytes = held_bytes + b;
        end
      end
      OpDeq: begin
        if (held_frames.size() > 0) begin
          f = held_frames.pop_front();
          held_bytes = held_bytes - f.len;
          r.deq_valid = 1'b1;
          r.deq_handle = f.handle;
          r.deq_bytes = f.len;
        end
      end
      OpClear: begin
        held_frames.delete();
        held_bytes = '0;
      end
      default: ;
    endcase
    r.occupancy = 7'(held_frames.size());
    r.byte_total = held_bytes;
  endtask

  task automatic send_word(input logic [OpW-1:0] op, input logic [15:0] h,
                           input logic [15:0] b);
    qres_t exp;
    @(negedge clk_i);
    if (!no_gaps && $urandom_range(99) < 5) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk_i);
    end
    start <= 1'b1;
    op_i <= op;
    frame_handle_i <= h;
    frame_bytes_i <= b;
    do @(posedge clk_i); while (busy !== 1'b0);
    predict_queue(op, h, b, exp);
    pending_results.push_back(exp);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    if (idx == RegMaxFrames) limit_reg = val;
    else drop_new_reg = val[0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin : check_results
    qres_t got;
    qres_t exp;
    if (rst_ni && done_o !== 1'b0) begin
      got = {deq_valid_o, deq_handle_o, deq_bytes_o, dropped_o, dropped_handle_o,
             occupancy_o, byte_total_o};
      if (pending_results.size() == 0) begin
        if (mismatches < 10) $display("%0t: result word with none pending", $time);
        mismatches++;
      end else begin
        exp = pending_results.pop_front();
        if (got !== exp) begin
          if (mismatches < 10) begin
            $display("%0t: mismatch exp dv=%b dh=%h db=%h dr=%b drh=%h occ=%0d tot=%0d",
                     $time, exp.deq_valid, exp.deq_handle, exp.deq_bytes, exp.dropped,
                     exp.dropped_handle, exp.occupancy, exp.byte_total);
            $display("%0t:          got dv=%b dh=%h db=%h dr=%b drh=%h occ=%0d tot=%0d",
                     $time, got.deq_valid, got.deq_handle, got.deq_bytes, got.dropped,
                     got.dropped_handle, got.occupancy, got.byte_total);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && busy === 1'b0) || done_o === 1'b1 || cfg_we_i) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic test_idle_ops();
    send_word(OpIdle, 16'hFFFF, 16'hFFFF);
    send_word(OpDeq, 16'($urandom), 16'($urandom));
    send_word(OpClear, 16'($urandom), 16'($urandom));
  endtask

  task automatic test_field_extremes();
    send_word(OpEnq, 16'h0000, 16'h0000);
    send_word(OpEnq, 16'hFFFF, 16'hFFFF);
    send_word(OpIdle, 16'h0000, 16'h0000);
    repeat (3) send_word(OpDeq, 16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_drop_policy();
    set_reg(RegMaxFrames, 7'd2);
    set_reg(RegDropNew, 7'd0);
    send_word(OpEnq, 16'h0101, 16'd100);
    send_word(OpEnq, 16'h0202, 16'd200);
    send_word(OpEnq, 16'h0303, 16'd300);
    set_reg(RegDropNew, 7'd1);
    send_word(OpEnq, 16'h0404, 16'd400);
    repeat (2) send_word(OpDeq, 16'h0000, 16'h0000);
  endtask

  task automatic test_zero_limit();
    set_reg(RegMaxFrames, 7'd64);
    send_word(OpEnq, 16'h0707, 16'd70);
    set_reg(RegMaxFrames, 7'd0);
    send_word(OpEnq, 16'h0808, 16'd80);
    set_reg(RegDropNew, 7'd0);
    send_word(OpEnq, 16'h0909, 16'd90);
    send_word(OpDeq, 16'h0000, 16'h0000);
  endtask

  task automatic test_limit_below_fill();
    set_reg(RegMaxFrames, 7'd64);
    for (int i = 0; i < 4; i++) send_word(OpEnq, 16'h1000 + 16'(i), 16'd1000 + 16'(i));
    set_reg(RegMaxFrames, 7'd2);
    send_word(OpEnq, 16'h2000, 16'd2000);
    set_reg(RegDropNew, 7'd1);
    send_word(OpEnq, 16'h3000, 16'd3000);
    send_word(OpClear, 16'h0000, 16'h0000);
  endtask

  // fill to full depth with max-length frames; limit above depth saturates
  task automatic test_full_depth();
    set_reg(RegMaxFrames, 7'd127);
    set_reg(RegDropNew, 7'd0);
    send_word(OpClear, 16'($urandom), 16'($urandom));
    repeat (64) send_word(OpEnq, 16'($urandom), 16'hFFFF);
    send_word(OpEnq, 16'($urandom), 16'hFFFF);
    set_reg(RegDropNew, 7'd1);
    send_word(OpEnq, 16'($urandom), 16'($urandom));
    repeat (65) send_word(OpDeq, 16'($urandom), 16'($urandom));
  endtask

  task automatic run_mix(input int unsigned n, input int unsigned enq_pct);
    int unsigned r;
    logic [OpW-1:0] op;
    logic [15:0] b;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < enq_pct) op = OpEnq;
      else if (r < 97) op = OpDeq;
      else if (r < 99) op = OpClear;
      else op = OpIdle;
      case ($urandom_range(9))
        0: b = 16'h0000;
        1: b = 16'hFFFF;
        default: b = 16'($urandom);
      endcase
      send_word(op, 16'($urandom), b);
    end
  endtask

  task automatic test_random_traffic();
    logic [6:0] lim;
    int unsigned pct;
    for (int p = 0; p < 12; p++) begin
      case (p % 6)
        0: lim = 7'd64;
        1: lim = 7'($urandom_range(8, 1));
        2: lim = 7'($urandom_range(63, 9));
        3: lim = 7'($urandom_range(127, 65));
        4: lim = 7'd0;
        default: lim = 7'($urandom_range(64, 0));
      endcase
      set_reg(RegMaxFrames, lim);
      set_reg(RegDropNew, 7'($urandom_range(1)));
      case (p % 3)
        0: pct = 70;
        1: pct = 50;
        default: pct = 35;
      endcase
      no_gaps = (p == 5);
      run_mix(130, pct);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    test_idle_ops();
    test_field_extremes();
    test_drop_policy();
    test_zero_limit();
    test_limit_below_fill();
    test_full_depth();
    test_random_traffic();
    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
